// ===== rtl/core/u8u16_pkg.sv =====
`default_nettype none

package u8u16_pkg;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_LEAD = 2'd1,
    ST_TOO_BIG  = 2'd2,
    ST_TRUNC    = 2'd3
  } status_t;

  localparam int CP_W = 21;

  localparam logic [CP_W-1:0] CP_MAX    = 21'h10FFFF;
  localparam logic [CP_W-1:0] SUPP_BASE = 21'h010000;
  localparam logic [15:0]     SUR_HIGH  = 16'hD800;
  localparam logic [15:0]     SUR_LOW   = 16'hDC00;

  // One decoded item handed from the front end to the emitter.
  // code is zero for every error item.
  typedef struct packed {
    logic [CP_W-1:0] code;
    status_t         status;
    logic            eos;
  } job_t;

endpackage

`default_nettype wire

// ===== rtl/core/u8u16_front.sv =====
`default_nettype none

module u8u16_front (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          accept,
  input  wire logic [7:0]    byte_in,
  input  wire logic          eos,
  output logic               push,
  output u8u16_pkg::job_t    push_job
);
  import u8u16_pkg::*;

  logic [CP_W-1:0] acc_r, acc_nxt;
  logic [1:0]      rem_r, rem_nxt;
  logic            drop_r, drop_nxt;

  logic [CP_W-1:0] acc_w;
  logic [1:0]      rem_w;
  logic            complete;
  logic            is_err;
  status_t         err_code;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      rem_r  <= '0;
      drop_r <= 1'b0;
    end else begin
      acc_r  <= acc_nxt;
      rem_r  <= rem_nxt;
      drop_r <= drop_nxt;
    end
  end

  always_comb begin
    acc_nxt  = acc_r;
    rem_nxt  = rem_r;
    drop_nxt = drop_r;
    push     = 1'b0;
    push_job = '0;
    acc_w    = acc_r;
    rem_w    = rem_r;
    complete = 1'b0;
    is_err   = 1'b0;
    err_code = ST_OK;

    if (accept) begin
      if (drop_r) begin
        // discard until the string closes
        if (eos) begin
          drop_nxt = 1'b0;
        end
      end else begin
        if (rem_r == 2'd0) begin
          if (!byte_in[7]) begin
            acc_w    = {{(CP_W-8){1'b0}}, byte_in};
            complete = 1'b1;
          end else if (byte_in[7:5] == 3'b110) begin
            acc_w = {{(CP_W-5){1'b0}}, byte_in[4:0]};
            rem_w = 2'd1;
          end else if (byte_in[7:4] == 4'b1110) begin
            acc_w = {{(CP_W-4){1'b0}}, byte_in[3:0]};
            rem_w = 2'd2;
          end else if (byte_in[7:3] == 5'b11110) begin
            acc_w = {{(CP_W-3){1'b0}}, byte_in[2:0]};
            rem_w = 2'd3;
          end else begin
            is_err   = 1'b1;
            err_code = ST_BAD_LEAD;
          end
        end else begin
          // continuation tag bits are not checked
          acc_w    = {acc_r[CP_W-7:0], byte_in[5:0]};
          rem_w    = rem_r - 2'd1;
          complete = (rem_r == 2'd1);
        end

        acc_nxt = acc_w;
        rem_nxt = rem_w;

        if (complete) begin
          acc_nxt = '0;
          if (acc_w <= CP_MAX) begin
            push            = 1'b1;
            push_job.code   = acc_w;
            push_job.status = ST_OK;
            push_job.eos    = eos;
          end else begin
            is_err   = 1'b1;
            err_code = ST_TOO_BIG;
          end
        end

        if (is_err) begin
          push            = 1'b1;
          push_job.code   = '0;
          push_job.status = err_code;
          push_job.eos    = eos;
          acc_nxt         = '0;
          rem_nxt         = '0;
          drop_nxt        = !eos;
        end else if (eos && (rem_w != 2'd0)) begin
          push            = 1'b1;
          push_job.code   = '0;
          push_job.status = ST_TRUNC;
          push_job.eos    = 1'b1;
          acc_nxt         = '0;
          rem_nxt         = '0;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8u16_queue.sv =====
`default_nettype none

module u8u16_queue #(
  parameter int DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire u8u16_pkg::job_t push_job,
  input  wire logic          pop,
  output u8u16_pkg::job_t    head,
  output logic               full,
  output logic               empty
);
  import u8u16_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

  job_t             slots_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign full  = (count_r == FULL_CNT);
  assign empty = (count_r == '0);
  assign head  = slots_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_SLOT) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_SLOT) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/u8u16_back.sv =====
`default_nettype none

module u8u16_back (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire u8u16_pkg::job_t head,
  input  wire logic            empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire logic            out_ready,
  output logic [15:0]          out_code,
  output u8u16_pkg::status_t   out_status,
  output logic                 out_lor,
  output logic                 out_los
);
  import u8u16_pkg::*;

  logic            valid_r, valid_nxt;
  logic            phase_r, phase_nxt;
  logic [15:0]     code_r, code_nxt;
  status_t         status_r, status_nxt;
  logic            lor_r, lor_nxt;
  logic            los_r, los_nxt;

  logic            load;
  logic            is_pair;
  logic [CP_W-1:0] offs;
  logic [15:0]     unit_high;
  logic [15:0]     unit_low;

  assign offs      = head.code - SUPP_BASE;
  assign unit_high = SUR_HIGH | {6'd0, offs[19:10]};
  assign unit_low  = SUR_LOW  | {6'd0, offs[9:0]};
  assign is_pair   = (head.status == ST_OK) && (head.code[CP_W-1:16] != '0);
  assign load      = !valid_r || out_ready;

  always_comb begin
    valid_nxt  = valid_r;
    phase_nxt  = phase_r;
    code_nxt   = code_r;
    status_nxt = status_r;
    lor_nxt    = lor_r;
    los_nxt    = los_r;
    pop        = 1'b0;
    if (load) begin
      if (phase_r) begin
        // second half of a surrogate pair
        valid_nxt  = 1'b1;
        code_nxt   = unit_low;
        status_nxt = ST_OK;
        lor_nxt    = 1'b1;
        los_nxt    = head.eos;
        phase_nxt  = 1'b0;
        pop        = 1'b1;
      end else if (!empty) begin
        valid_nxt  = 1'b1;
        status_nxt = head.status;
        if (is_pair) begin
          code_nxt  = unit_high;
          lor_nxt   = 1'b0;
          los_nxt   = 1'b0;
          phase_nxt = 1'b1;
        end else begin
          code_nxt = head.code[15:0];
          lor_nxt  = 1'b1;
          los_nxt  = head.eos;
          pop      = 1'b1;
        end
      end else begin
        valid_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      phase_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r   <= code_nxt;
    status_r <= status_nxt;
    lor_r    <= lor_nxt;
    los_r    <= los_nxt;
  end

  assign out_valid  = valid_r;
  assign out_code   = code_r;
  assign out_status = status_r;
  assign out_lor    = lor_r;
  assign out_los    = los_r;

endmodule

`default_nettype wire

// ===== rtl/core/utf8_to_utf16_transcoder_core.sv =====
`default_nettype none

// UTF-8 to UTF-16 transcoder.
//
// Input channel (in_*): one UTF-8 byte per transfer in in_tdata, with in_tlast
// marking the final byte of a string. Output channel (out_*): one UTF-16 code
// unit per transfer in out_tdata, its status and a last-of-run flag in
// out_tuser, and out_tlast on the result that closes a string.
//
// A byte that completes a code point above 0xFFFF yields a surrogate pair,
// high unit first. A bad lead byte or an out-of-range code point yields one
// error result with a zero code unit; the rest of that string is dropped.
// A string that ends inside a sequence yields one truncated result.
//
// Throughput: one byte per cycle while the queue has room, one result per
// cycle while out_tready is high. A pair only follows a four-byte sequence,
// so the stream keeps pace. A result passes through the queue and then the
// output register before it shows on out_tvalid; the low half of a pair
// is loaded into the output register once the high half is taken.
// The decoder front end writes into a QUEUE_DEPTH-entry queue; the emitter
// drains it into an output register. When the receiver stalls, hold the
// output and keep accepting bytes until the queue fills, then drop in_tready.
// Reset clears the decoder state, empties the queue and clears out_tvalid.
module utf8_to_utf16_transcoder_core #(
  parameter int QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [7:0]  in_tdata,   // [7:0] byte_in
  input  wire logic        in_tlast,   // end_of_string
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [15:0] code_unit
  output logic [2:0]       out_tuser,  // [1:0] status, [2] last_of_run
  output logic             out_tlast   // last_of_string
);
  import u8u16_pkg::*;

  logic    q_push;
  logic    q_pop;
  logic    q_full;
  logic    q_empty;
  job_t    q_in;
  job_t    q_head;
  logic    in_accept;
  status_t res_status;
  logic    res_lor;

  // Accept a byte whenever the queue has room, even with results waiting.
  assign in_tready = !q_full;
  assign in_accept = in_tvalid && in_tready;

  u8u16_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .accept   (in_accept),
    .byte_in  (in_tdata),
    .eos      (in_tlast),
    .push     (q_push),
    .push_job (q_in)
  );

  u8u16_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (q_in),
    .pop      (q_pop),
    .head     (q_head),
    .full     (q_full),
    .empty    (q_empty)
  );

  u8u16_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head       (q_head),
    .empty      (q_empty),
    .pop        (q_pop),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_code   (out_tdata),
    .out_status (res_status),
    .out_lor    (res_lor),
    .out_los    (out_tlast)
  );

  assign out_tuser = {res_lor, res_status};

  // A high surrogate is followed at once by its low surrogate.
  a_pair_follows : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tready && !out_tuser[2])
      |=> (out_tvalid && out_tdata[15:10] == 6'b110111))
    else $error("low surrogate did not follow high surrogate");

  // Error results carry a zero unit and end their run.
  a_err_shape : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser[1:0] != ST_OK) |-> (out_tdata == 16'd0 && out_tuser[2]))
    else $error("malformed error result");

  // Only the last result of a byte may close a string.
  a_close_last : assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tlast) |-> out_tuser[2])
    else $error("string closed mid-run");

endmodule

`default_nettype wire

// ===== test/utf8_to_utf16_transcoder_core_tb.sv =====
`timescale 1ns / 1ps

import u8u16_pkg::*;

// Tracks the decoder state and holds the UTF-16 results still due.
class transcode_scoreboard;
  typedef struct {
    logic [15:0] code_unit;
    status_t     status;
    logic        run_last;
    logic        str_last;
  } unit_exp_t;

  logic [CP_W-1:0] code_acc;
  logic [1:0]      bytes_left;
  logic            dropping;
  unit_exp_t       expected_units[$];
  int              mismatches;

  function new();
    code_acc   = '0;
    bytes_left = '0;
    dropping   = 1'b0;
    mismatches = 0;
  endfunction

  function int pending();
    return expected_units.size();
  endfunction

  function void push_unit(input logic [15:0] code_unit, input status_t status);
    unit_exp_t u;
    u.code_unit = code_unit;
    u.status    = status;
    u.run_last  = 1'b0;
    u.str_last  = 1'b0;
    expected_units.push_back(u);
  endfunction

  // Decode one accepted byte; return 0 when the byte is discarded after an error.
  function bit note_byte(input logic [7:0] b, input logic eos);
    int              first;
    bit              complete;
    status_t         fault;
    unit_exp_t       tail;
    logic [CP_W-1:0] offset;
    first    = expected_units.size();
    complete = 1'b0;
    fault    = ST_OK;
    if (dropping) begin
      if (eos) dropping = 1'b0;
      return 1'b0;
    end
    if (bytes_left == 2'd0) begin
      casez (b)
        8'b0???_????: begin
          code_acc = {13'd0, b};
          complete = 1'b1;
        end
        8'b110?_????: begin
          code_acc   = {16'd0, b[4:0]};
          bytes_left = 2'd1;
        end
        8'b1110_????: begin
          code_acc   = {17'd0, b[3:0]};
          bytes_left = 2'd2;
        end
        8'b1111_0???: begin
          code_acc   = {18'd0, b[2:0]};
          bytes_left = 2'd3;
        end
        default: fault = ST_BAD_LEAD;
      endcase
    end else begin
      // tag bits of the continuation byte are not checked
      code_acc   = {code_acc[CP_W-7:0], b[5:0]};
      bytes_left = bytes_left - 2'd1;
      complete   = (bytes_left == 2'd0);
    end
    if (complete) begin
      if (code_acc <= 21'h00FFFF) begin
        push_unit(code_acc[15:0], ST_OK);
      end else if (code_acc <= CP_MAX) begin
        offset = code_acc - SUPP_BASE;
        push_unit(SUR_HIGH | {6'd0, offset[19:10]}, ST_OK);
        push_unit(SUR_LOW | {6'd0, offset[9:0]}, ST_OK);
      end else begin
        fault = ST_TOO_BIG;
      end
      code_acc = '0;
    end
    if (fault != ST_OK) begin
      push_unit(16'd0, fault);
      code_acc   = '0;
      bytes_left = 2'd0;
      if (!eos) dropping = 1'b1;
    end else if (eos && bytes_left != 2'd0) begin
      push_unit(16'd0, ST_TRUNC);
      code_acc   = '0;
      bytes_left = 2'd0;
    end
    // flag the final result of this byte
    if (expected_units.size() > first) begin
      tail          = expected_units.pop_back();
      tail.run_last = 1'b1;
      tail.str_last = eos;
      expected_units.push_back(tail);
    end
    return 1'b1;
  endfunction

  function void check_unit(input logic [15:0] data, input logic [2:0] user,
                           input logic last);
    unit_exp_t want;
    if (expected_units.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("unexpected result at %0t: unit %h status %0d run_last %b string_last %b",
                 $time, data, user[1:0], user[2], last);
      return;
    end
    want = expected_units.pop_front();
    if (data !== want.code_unit || user[1:0] !== want.status ||
        user[2] !== want.run_last || last !== want.str_last) begin
      mismatches++;
      if (mismatches <= 10)
        $display({"mismatch at %0t: expected unit %h status %0d run_last %b string_last %b,",
                  " got unit %h status %0d run_last %b string_last %b"},
                 $time, want.code_unit, want.status, want.run_last, want.str_last,
                 data, user[1:0], user[2], last);
    end
  endfunction
endclass

module utf8_to_utf16_transcoder_core_tb;

  // {end_of_string, byte}
  localparam logic [8:0] DIRECTED [23] = '{
    9'h000, 9'h07F,                         // ASCII extremes
    9'h0C2, 9'h0A9,                         // two-byte sequence
    9'h0EF, 9'h0BF, 9'h0BF,                 // largest BMP code point
    9'h0F4, 9'h08F, 9'h0BF, 9'h1BF,         // largest code point, pair closes string
    9'h0F7, 9'h0BF, 9'h0BF, 9'h0BF,         // above the Unicode range, then drop
    9'h141,                                 // dropped byte ends the string
    9'h080,                                 // continuation byte in lead position
    9'h100,                                 // dropped, ends string
    9'h1F8,                                 // bad lead on the final byte
    9'h1C3,                                 // string ends on a lead byte
    9'h0F0, 9'h190,                         // string ends inside a sequence
    9'h1FF                                  // top byte value
  };

  logic       clk        = 1'b0;
  logic       rst_n      = 1'b0;
  logic       in_tvalid  = 1'b0;
  logic [7:0] in_tdata   = 8'd0;
  logic       in_tlast   = 1'b0;
  logic       out_tready = 1'b0;
  wire        in_tready;
  wire        out_tvalid;
  wire [15:0] out_tdata;
  wire [2:0]  out_tuser;
  wire        out_tlast;

  transcode_scoreboard sb;
  int sent_count  = 0;
  int taken_count = 0;
  bit send_calm   = 1'b0;
  bit recv_calm   = 1'b0;
  bit paused      = 1'b0;

  utf8_to_utf16_transcoder_core i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic send_byte(input logic [7:0] b, input logic eos);
    int gap;
    if (sent_count % 40 == 0) send_calm = ($urandom_range(0, 3) == 0);
    sent_count++;
    gap = send_calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= eos;
    do @(posedge clk); while (!in_tready);
    void'(sb.note_byte(b, eos));
  endtask

  // Mostly well-formed characters, some noise bytes and cut-off sequences.
  task automatic send_string();
    logic [7:0] str_bytes[$];
    logic [7:0] lead;
    int         n_chars;
    int         kind;
    int         len;
    int         keep;
    n_chars = $urandom_range(1, 8);
    for (int i = 0; i < n_chars; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 8) begin
        str_bytes.push_back(8'($urandom));
        continue;
      end
      len = (kind < 30) ? 1 : (kind < 50) ? 2 : (kind < 70) ? 3 : 4;
      case (len)
        1: lead = 8'($urandom_range(8'h00, 8'h7F));
        2: lead = 8'($urandom_range(8'hC0, 8'hDF));
        3: lead = 8'($urandom_range(8'hE0, 8'hEF));
        default: begin
          if ($urandom_range(0, 6) == 0) lead = 8'($urandom_range(8'hF0, 8'hF7));
          else lead = 8'($urandom_range(8'hF0, 8'hF4));
        end
      endcase
      keep = (kind >= 94 && len > 1) ? $urandom_range(1, len - 1) : len;
      str_bytes.push_back(lead);
      for (int j = 1; j < keep; j++) begin
        if ($urandom_range(0, 15) == 0) str_bytes.push_back(8'($urandom));
        else str_bytes.push_back({2'b10, 6'($urandom)});
      end
      if (keep < len) break;
    end
    for (int i = 0; i < str_bytes.size(); i++)
      send_byte(str_bytes[i], i == str_bytes.size() - 1);
  endtask

  // Hold the input idle until every expected result has come out.
  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    sb = new();
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    foreach (DIRECTED[i]) send_byte(DIRECTED[i][7:0], DIRECTED[i][8]);
    drain_results();
    while (sent_count < 1050) begin
      if (!paused && sent_count >= 500) begin
        paused = 1'b1;
        drain_results();
      end
      send_string();
    end
    drain_results();
    repeat (20) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

  // Receiver: stall a random number of cycles before each transfer.
  initial begin
    int gap;
    do @(posedge clk); while (!rst_n);
    forever begin
      if (taken_count % 40 == 0) recv_calm = ($urandom_range(0, 3) == 0);
      gap = recv_calm ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
        out_tready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
      taken_count++;
      sb.check_unit(out_tdata, out_tuser, out_tlast);
    end
  end

  initial begin
    #5_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
